>>> design/gye_pkg.sv
// Shared types and constants for the gyro yaw estimator.
package gye_pkg;

  localparam int CalMaxDef  = 4096;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [2:0] OpSample    = 3'd0;
  localparam logic [2:0] OpTick      = 3'd1;
  localparam logic [2:0] OpCalClear  = 3'd2;
  localparam logic [2:0] OpCalSample = 3'd3;
  localparam logic [2:0] OpCalFinish = 3'd4;

  localparam int RateScale = 35764;
  localparam int FiltKeep  = 45875;
  localparam int FiltNew   = 19661;
  localparam int RateMax   = 16777215;
  localparam int RateMin   = -16777216;
  localparam int AbsMax    = 16777215;
  localparam int PiQ28     = 843314857;
  localparam int TwoPiQ28  = 1686629713;
  localparam int BiasMax   = 8388607;
  localparam int BiasNegLim = 8388608;

  typedef enum logic [2:0] {
    KIND_SAMPLE,
    KIND_TICK,
    KIND_CAL_CLEAR,
    KIND_CAL_ADD,
    KIND_CAL_FINISH,
    KIND_NONE
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] raw;
    logic [23:0]        dt;
  } entry_t;

endpackage

>>> design/gye_front.sv
// Request front end: decodes the operation and queues requests for the back end.
module gye_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [2:0]         operation_i,
  input  logic signed [15:0] raw_rate_i,
  input  logic [23:0]        time_step_i,
  output gye_pkg::entry_t    head_o,
  output logic               head_valid_o,
  input  logic               pop_i
);
  import gye_pkg::*;

  entry_t            entry_q [QueueDepth];
  entry_t            entry_in;
  kind_e             kind;
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  fill_q, fill_d;
  logic              push, pop;

  always_comb begin
    unique case (operation_i)
      OpSample:    kind = KIND_SAMPLE;
      OpTick:      kind = KIND_TICK;
      OpCalClear:  kind = KIND_CAL_CLEAR;
      OpCalSample: kind = KIND_CAL_ADD;
      OpCalFinish: kind = KIND_CAL_FINISH;
      default:     kind = KIND_NONE;
    endcase
  end

  assign entry_in     = '{kind: kind, raw: raw_rate_i, dt: time_step_i};
  assign stall_o      = (fill_q == QCntW'(QueueDepth));
  assign head_valid_o = (fill_q != '0);
  assign head_o       = entry_q[rd_ptr_q];
  assign push         = valid_i && !stall_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= entry_in;
    end
  end

endmodule

>>> design/gye_div.sv
// Bit-serial restoring divider for unsigned operands, one quotient bit per cycle.
module gye_div #(
  parameter int DvdW = 37,
  parameter int DsrW = 13
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DsrW-1:0] divisor_i,
  output logic            done_o,
  output logic [DvdW-1:0] quotient_o
);

  localparam int StepW = $clog2(DvdW + 1);

  logic             busy_q, busy_d, done_q, done_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [DvdW-1:0]  quo_q, quo_d;
  logic [DsrW-1:0]  rem_q, rem_d, dsr_q, dsr_d;
  logic [DsrW:0]    trial, diff;
  logic             ge;

  assign trial = {rem_q, quo_q[DvdW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = (trial >= {1'b0, dsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = StepW'(DvdW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DvdW-2:0], ge};
      rem_d = ge ? diff[DsrW-1:0] : trial[DsrW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> design/gye_back.sv
// Back end: sequencer with a shared multiplier, calibration and the result register.
module gye_back #(
  parameter int CAL_MAX = gye_pkg::CalMaxDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gye_pkg::entry_t    head_i,
  input  logic               head_valid_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [24:0] filtered_rate_o,
  output logic [23:0]        instability_o,
  output logic signed [30:0] heading_o,
  output logic signed [23:0] bias_o
);
  import gye_pkg::*;

  localparam int CntW = $clog2(CAL_MAX + 1);
  localparam int SumW = 16 + CntW;
  localparam int DvdW = SumW + 8;

  typedef enum logic [9:0] {
    BK_IDLE  = 10'b0000000001,
    BK_SM1   = 10'b0000000010,
    BK_SM2   = 10'b0000000100,
    BK_SM3   = 10'b0000001000,
    BK_SM4   = 10'b0000010000,
    BK_TMUL  = 10'b0000100000,
    BK_TADD  = 10'b0001000000,
    BK_TWRAP = 10'b0010000000,
    BK_DIV   = 10'b0100000000,
    BK_DONE  = 10'b1000000000
  } bk_state_e;

  bk_state_e state_q, state_d;

  logic signed [24:0]     f_q, f_d;
  logic [23:0]            abs_q, abs_d;
  logic signed [30:0]     yaw_q, yaw_d;
  logic signed [23:0]     bias_q, bias_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   ovalid_q, ovalid_d;

  logic [23:0]            dt_q, dt_d;
  logic signed [24:0]     d_q, d_d;
  logic signed [25:0]     x_q, x_d;
  logic signed [50:0]     prod_q, prod_d, acc_q, acc_d;
  logic signed [33:0]     y_q, y_d;
  logic                   neg_q, neg_d;

  logic signed [25:0]     mul_a;
  logic signed [24:0]     mul_b;
  logic signed [50:0]     mul_p;
  logic signed [50:0]     fsum, fsh;
  logic signed [26:0]     ax;
  logic signed [33:0]     yw;
  logic [SumW-1:0]        sum_mag;
  logic                   div_start, div_done, load;
  logic [DvdW-1:0]        quo;

  gye_div #(
    .DvdW(DvdW),
    .DsrW(CntW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({sum_mag, 8'b0}),
    .divisor_i (cnt_q),
    .done_o    (div_done),
    .quotient_o(quo)
  );

  assign sum_mag = sum_q[SumW-1] ? SumW'(-sum_q) : sum_q;

  always_comb begin
    mul_a = {f_q[24], f_q};
    mul_b = '0;
    unique case (state_q)
      BK_SM1:  begin
        mul_a = {d_q[24], d_q};
        mul_b = 25'(RateScale);
      end
      BK_SM2:  mul_b = 25'(FiltKeep);
      BK_SM3:  begin
        mul_a = x_q;
        mul_b = 25'(FiltNew);
      end
      BK_TMUL: mul_b = {1'b0, dt_q};
      default: mul_b = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign fsum  = acc_q + prod_q;
  assign fsh   = fsum >>> 16;
  assign ax    = x_q[25] ? -{x_q[25], x_q} : {x_q[25], x_q};

  always_comb begin
    if (y_q > 34'(PiQ28)) begin
      yw = y_q - 34'(TwoPiQ28);
    end else if (y_q < 34'(-PiQ28)) begin
      yw = y_q + 34'(TwoPiQ28);
    end else begin
      yw = y_q;
    end
  end

  always_comb begin
    state_d   = state_q;
    f_d       = f_q;
    abs_d     = abs_q;
    yaw_d     = yaw_q;
    bias_d    = bias_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    dt_d      = dt_q;
    d_d       = d_q;
    x_d       = x_q;
    prod_d    = prod_q;
    acc_d     = acc_q;
    y_d       = y_q;
    neg_d     = neg_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    load      = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (head_valid_i) begin
          pop_o   = 1'b1;
          dt_d    = head_i.dt;
          state_d = BK_DONE;
          case (head_i.kind)
            KIND_SAMPLE: begin
              d_d     = {head_i.raw[15], head_i.raw, 8'b0} - {bias_q[23], bias_q};
              state_d = BK_SM1;
            end
            KIND_TICK: state_d = BK_TMUL;
            KIND_CAL_CLEAR: begin
              sum_d = '0;
              cnt_d = '0;
            end
            KIND_CAL_ADD: begin
              if (cnt_q < CntW'(CAL_MAX)) begin
                sum_d = sum_q + {{(SumW-16){head_i.raw[15]}}, head_i.raw};
                cnt_d = cnt_q + 1'b1;
              end
            end
            KIND_CAL_FINISH: begin
              if (cnt_q != '0) begin
                div_start = 1'b1;
                neg_d     = sum_q[SumW-1];
                state_d   = BK_DIV;
              end
            end
            default: state_d = BK_DONE;
          endcase
        end
      end
      BK_SM1: begin
        prod_d  = mul_p;
        state_d = BK_SM2;
      end
      BK_SM2: begin
        x_d     = prod_q[41:16];
        prod_d  = mul_p;
        state_d = BK_SM3;
      end
      BK_SM3: begin
        acc_d   = prod_q;
        prod_d  = mul_p;
        state_d = BK_SM4;
      end
      BK_SM4: begin
        if (fsh > 51'(RateMax)) begin
          f_d = 25'(RateMax);
        end else if (fsh < 51'(RateMin)) begin
          f_d = 25'(RateMin);
        end else begin
          f_d = fsh[24:0];
        end
        abs_d   = (ax > 27'(AbsMax)) ? 24'(AbsMax) : ax[23:0];
        state_d = BK_DONE;
      end
      BK_TMUL: begin
        prod_d  = mul_p;
        state_d = BK_TADD;
      end
      BK_TADD: begin
        y_d     = {{3{yaw_q[30]}}, yaw_q} + prod_q[49:16];
        state_d = BK_TWRAP;
      end
      BK_TWRAP: begin
        if (yw > 34'(PiQ28)) begin
          yaw_d = 31'(PiQ28);
        end else if (yw < 34'(-PiQ28)) begin
          yaw_d = 31'(-PiQ28);
        end else begin
          yaw_d = yw[30:0];
        end
        state_d = BK_DONE;
      end
      BK_DIV: begin
        if (div_done) begin
          if (neg_q) begin
            bias_d = (quo > DvdW'(BiasNegLim)) ? 24'(-BiasNegLim) : -quo[23:0];
          end else begin
            bias_d = (quo > DvdW'(BiasMax)) ? 24'(BiasMax) : quo[23:0];
          end
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!ovalid_q || !out_stall_i) begin
          load    = 1'b1;
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    if (load) begin
      ovalid_d = 1'b1;
    end else if (!out_stall_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      f_q      <= '0;
      abs_q    <= '0;
      yaw_q    <= '0;
      bias_q   <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      f_q      <= f_d;
      abs_q    <= abs_d;
      yaw_q    <= yaw_d;
      bias_q   <= bias_d;
      sum_q    <= sum_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q   <= dt_d;
    d_q    <= d_d;
    x_q    <= x_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    y_q    <= y_d;
    neg_q  <= neg_d;
    if (load) begin
      filtered_rate_o <= f_q;
      instability_o   <= abs_q;
      heading_o       <= yaw_q;
      bias_o          <= bias_q;
    end
  end

  assign out_valid_o = ovalid_q;

  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAL_MAX))
    else $error("calibration count above limit");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == BK_DIV)
    else $error("divider finished outside divide state");

  a_yaw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (yaw_q <= 31'(PiQ28)) && (yaw_q >= 31'(-PiQ28)))
    else $error("heading out of range");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DONE) && !(ovalid_q && out_stall_i) |=> ovalid_q && state_q == BK_IDLE)
    else $error("finished request did not load the result register");

endmodule

>>> design/gyro_yaw_estimator_unit.sv
// Gyro yaw estimator top level: request queue, sequencer and result register.
// Requests enter a two-entry queue and run one at a time; the result register lets the next
// request be taken while a result waits. After the queue pop, a sample makes three passes through
// the shared multiplier and then saturates; a tick multiplies, adds and wraps; calibration clear
// or sample updates the sum and count directly; calibration finish with samples present runs the
// one-bit-per-cycle divider; finish with no samples goes straight to the result register.
module gyro_yaw_estimator_unit #(
  parameter int CAL_MAX = gye_pkg::CalMaxDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         operation_i,
  input  logic signed [15:0] raw_rate_i,
  input  logic [23:0]        time_step_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [24:0] filtered_rate_o,
  output logic [23:0]        instability_o,
  output logic signed [30:0] heading_o,
  output logic signed [23:0] bias_o
);
  import gye_pkg::*;

  entry_t head;
  logic   head_valid, pop;

  gye_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .stall_o     (in_stall_o),
    .operation_i (operation_i),
    .raw_rate_i  (raw_rate_i),
    .time_step_i (time_step_i),
    .head_o      (head),
    .head_valid_o(head_valid),
    .pop_i       (pop)
  );

  gye_back #(
    .CAL_MAX(CAL_MAX)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .head_valid_i   (head_valid),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .filtered_rate_o(filtered_rate_o),
    .instability_o  (instability_o),
    .heading_o      (heading_o),
    .bias_o         (bias_o)
  );

endmodule
